// ===== rtl/core/mhsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhsi_pkg;

    localparam int MHSI_COEF_BITS = 20;
    localparam int CFG_W          = 60;
    localparam int OFFSET_W       = 21;
    localparam int RAW_W          = 20;
    localparam int D_W            = 22;
    localparam int FRAC_SHIFT     = 15;
    localparam int OUT_W          = 32;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd5;

    typedef logic signed [D_W-1:0] mhsi_d_t;

    typedef struct packed {
        logic adv_b;
        logic adv_c;
    } mhsi_adv_t;

endpackage

`default_nettype wire

// ===== rtl/core/mhsi_row.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhsi_row #(
    parameter int COEF_BITS = mhsi_pkg::MHSI_COEF_BITS
) (
    input  wire logic                                clk,
    input  wire mhsi_pkg::mhsi_d_t [2:0]             d,
    input  wire logic [mhsi_pkg::CFG_W-1:0]          row,
    input  wire mhsi_pkg::mhsi_adv_t                 adv,
    output logic signed [mhsi_pkg::OUT_W-1:0]        field
);

    import mhsi_pkg::*;

    localparam int ROW_W  = (3 * COEF_BITS > CFG_W) ? 3 * COEF_BITS : CFG_W;
    localparam int PROD_W = D_W + COEF_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SHR_W  = SUM_W - FRAC_SHIFT;
    localparam int EXT_W  = (SHR_W > OUT_W) ? SHR_W : OUT_W + 1;
    localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'(64'sd2147483647);
    localparam logic signed [EXT_W-1:0] SAT_MIN = EXT_W'(-64'sd2147483648);
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 <<< (FRAC_SHIFT - 1));

    logic [ROW_W-1:0]                row_ext;
    logic signed [COEF_BITS-1:0]     coef [3];
    logic signed [PROD_W-1:0]        prod_next [3];
    logic signed [PROD_W-1:0]        prod_reg [3];
    logic signed [SUM_W-1:0]         sum;
    logic signed [SHR_W-1:0]         shr;
    logic signed [EXT_W-1:0]         shr_ext;
    logic signed [OUT_W-1:0]         field_next;
    logic signed [OUT_W-1:0]         field_reg;

    assign row_ext = ROW_W'(row);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            coef[c]      = signed'(row_ext[c*COEF_BITS +: COEF_BITS]);
            prod_next[c] = PROD_W'(d[c]) * PROD_W'(coef[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.adv_b)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    // round half up, then floor shift, then saturate to the signed 32-bit range
    always_comb
    begin
        sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]) + ROUND_HALF;
        shr = signed'(sum[SUM_W-1:FRAC_SHIFT]);
        shr_ext = EXT_W'(shr);
        if (shr_ext > SAT_MAX)
        begin
            field_next = OUT_W'(SAT_MAX);
        end
        else if (shr_ext < SAT_MIN)
        begin
            field_next = OUT_W'(SAT_MIN);
        end
        else
        begin
            field_next = OUT_W'(shr_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.adv_c)
        begin
            field_reg <= field_next;
        end
    end

    assign field = field_reg;

endmodule

`default_nettype wire

// ===== rtl/core/magnetometer_hard_soft_iron_correct.sv =====
// multiply-accumulate pipeline of three registered stages: frame/offset, multiply, sum
// throughput: one request per cycle while out_stall does not hold the pipeline
// a request is taken while a finished result waits, as long as a stage is free
// reset: rst_n asynchronous active low, clears pipeline valids and all config registers
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_hard_soft_iron_correct #(
    parameter int COEF_BITS = mhsi_pkg::MHSI_COEF_BITS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [mhsi_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mhsi_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [7:0]                           x_high_byte,
    input  wire logic [7:0]                           x_mid_byte,
    input  wire logic [7:0]                           y_high_byte,
    input  wire logic [7:0]                           y_mid_byte,
    input  wire logic [7:0]                           z_high_byte,
    input  wire logic [7:0]                           z_mid_byte,
    input  wire logic [7:0]                           x_nibble_byte,
    input  wire logic [7:0]                           y_nibble_byte,
    input  wire logic [7:0]                           z_nibble_byte,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [mhsi_pkg::OUT_W-1:0]         field_x,
    output logic signed [mhsi_pkg::OUT_W-1:0]         field_y,
    output logic signed [mhsi_pkg::OUT_W-1:0]         field_z
);

    import mhsi_pkg::*;

    logic [CFG_W-1:0]              row_x_reg;
    logic [CFG_W-1:0]              row_y_reg;
    logic [CFG_W-1:0]              row_z_reg;
    logic signed [OFFSET_W-1:0]    off_x_reg;
    logic signed [OFFSET_W-1:0]    off_y_reg;
    logic signed [OFFSET_W-1:0]    off_z_reg;

    logic                          va_reg;
    logic                          vb_reg;
    logic                          vc_reg;
    logic                          ready_a;
    logic                          ready_b;
    logic                          ready_c;
    mhsi_adv_t                     adv;

    logic signed [RAW_W-1:0]       cx;
    logic signed [RAW_W-1:0]       cy;
    logic signed [RAW_W-1:0]       cz;
    mhsi_d_t [2:0]                 d_next;
    mhsi_d_t [2:0]                 d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= '0;
            row_y_reg <= '0;
            row_z_reg <= '0;
            off_x_reg <= '0;
            off_y_reg <= '0;
            off_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_X:    row_x_reg <= cfg_data;
                REG_ROW_Y:    row_y_reg <= cfg_data;
                REG_ROW_Z:    row_z_reg <= cfg_data;
                REG_OFFSET_X: off_x_reg <= signed'(cfg_data[OFFSET_W-1:0]);
                REG_OFFSET_Y: off_y_reg <= signed'(cfg_data[OFFSET_W-1:0]);
                REG_OFFSET_Z: off_z_reg <= signed'(cfg_data[OFFSET_W-1:0]);
                default:      ;
            endcase
        end
    end

    assign ready_c   = !vc_reg || !out_stall;
    assign ready_b   = !vb_reg || ready_c;
    assign ready_a   = !va_reg || ready_b;
    assign adv.adv_b = ready_b && va_reg;
    assign adv.adv_c = ready_c && vb_reg;
    assign in_stall  = !ready_a;
    assign out_valid = vc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
            if (ready_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    // removing mid-scale bias flips the top bit
    assign cx = signed'({~x_high_byte[7], x_high_byte[6:0], x_mid_byte, x_nibble_byte[7:4]});
    assign cy = signed'({~y_high_byte[7], y_high_byte[6:0], y_mid_byte, y_nibble_byte[7:4]});
    assign cz = signed'({~z_high_byte[7], z_high_byte[6:0], z_mid_byte, z_nibble_byte[7:4]});

    // ned frame: y and z negated, then the hard-iron offsets subtracted
    assign d_next[0] = D_W'(cx) - D_W'(off_x_reg);
    assign d_next[1] = -D_W'(cy) - D_W'(off_y_reg);
    assign d_next[2] = -D_W'(cz) - D_W'(off_z_reg);

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            d_reg <= d_next;
        end
    end

    mhsi_row #(.COEF_BITS(COEF_BITS)) u_row_x (
        .clk   (clk),
        .d     (d_reg),
        .row   (row_x_reg),
        .adv   (adv),
        .field (field_x)
    );

    mhsi_row #(.COEF_BITS(COEF_BITS)) u_row_y (
        .clk   (clk),
        .d     (d_reg),
        .row   (row_y_reg),
        .adv   (adv),
        .field (field_y)
    );

    mhsi_row #(.COEF_BITS(COEF_BITS)) u_row_z (
        .clk   (clk),
        .d     (d_reg),
        .row   (row_z_reg),
        .adv   (adv),
        .field (field_z)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mhsi_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhsi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] field_x,
    input wire logic [31:0] field_y,
    input wire logic [31:0] field_z
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(field_x) && $stable(field_y) && $stable(field_z))
        else $error("stalled result changed");

    // nothing waiting at the output means every stage can move
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with output empty");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("request did not reach output in three cycles");

endmodule

bind magnetometer_hard_soft_iron_correct mhsi_checker u_mhsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .field_x   (field_x),
    .field_y   (field_y),
    .field_z   (field_z)
);

`default_nettype wire
